// ===== hdl/keypad_code_alarm_controller_unit_macros.svh =====
// assertion macros for the keypad code alarm controller
`ifndef KEYPAD_CODE_ALARM_CONTROLLER_UNIT_MACROS_SVH
`define KEYPAD_CODE_ALARM_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define KCAC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KCAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/kcac_pkg.sv =====
// shared constants, types and helpers of the keypad code alarm controller
package kcac_pkg;

   localparam int AVG_DEPTH   = 100;
   localparam int CODE_LEN    = 4;
   localparam int SAMPLE_BITS = 12;

   localparam int PTR_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int POS_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
   localparam int SUM_W = $clog2(AVG_DEPTH * ((1 << SAMPLE_BITS) - 1) + 1);

   localparam logic [3:0] HASH_KEY = 4'd14;
   localparam logic [3:0] CNT_MAX  = 4'hF;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] CODE_WORD_RST       = 16'd23952;
   localparam logic [3:0]  DEBOUNCE_TICKS_RST  = 4'd4;
   localparam logic [18:0] TEMP_SUM_LIMIT_RST  = 19'd62045;
   localparam logic [3:0]  BLOCK_THRESHOLD_RST = 4'd3;

   typedef enum logic [1:0] {
      REG_CODE_WORD,
      REG_DEBOUNCE_TICKS,
      REG_TEMP_SUM_LIMIT,
      REG_BLOCK_THRESHOLD
   } reg_index_type;

   typedef enum logic [1:0] {
      SCAN_IDLE     = 2'd0,
      SCAN_DEBOUNCE = 2'd1,
      SCAN_HOLD     = 2'd2
   } scan_state_type;

   typedef struct packed {
      logic [15:0] code_word;
      logic [3:0]  debounce_ticks;
      logic [18:0] temp_sum_limit;
      logic [3:0]  block_threshold;
   } cfg_type;

   typedef struct packed {
      logic        gas_line;
      logic        test_button;
      logic [11:0] temp_sample;
      logic [15:0] key_matrix;
   } tick_type;

   typedef struct packed {
      logic       siren_on;
      logic       alarm_started;
      logic       incorrect_flag;
      logic       blocked_flag;
      logic       key_released_valid;
      logic [3:0] key_released_index;
   } result_type;

   // lowest pressed key: {found, index}
   function automatic logic [4:0] first_key(input logic [15:0] m);
      logic       found;
      logic [3:0] idx;
      found = 1'b0;
      idx   = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (m[i]) begin
            found = 1'b1;
            idx   = 4'(i);
         end
      end
      return {found, idx};
   endfunction

endpackage

// ===== hdl/kcac_csr.sv =====
// configuration register bank on the apb-style port
module kcac_csr import kcac_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CODE_WORD:       cfg_in.code_word       = csr_pwdata[15:0];
            REG_DEBOUNCE_TICKS:  cfg_in.debounce_ticks  = csr_pwdata[3:0];
            REG_TEMP_SUM_LIMIT:  cfg_in.temp_sum_limit  = csr_pwdata[18:0];
            REG_BLOCK_THRESHOLD: cfg_in.block_threshold = csr_pwdata[3:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CODE_WORD:       csr_prdata = CSR_DATA_W'(cfg_ff.code_word);
         REG_DEBOUNCE_TICKS:  csr_prdata = CSR_DATA_W'(cfg_ff.debounce_ticks);
         REG_TEMP_SUM_LIMIT:  csr_prdata = CSR_DATA_W'(cfg_ff.temp_sum_limit);
         REG_BLOCK_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.block_threshold);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_word       <= CODE_WORD_RST;
         cfg_ff.debounce_ticks  <= DEBOUNCE_TICKS_RST;
         cfg_ff.temp_sum_limit  <= TEMP_SUM_LIMIT_RST;
         cfg_ff.block_threshold <= BLOCK_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/kcac_ring.sv =====
// temperature sample ring memory with running sum
module kcac_ring import kcac_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fetch,
   input  logic                   commit,
   input  logic [SAMPLE_BITS-1:0] commit_sample,
   output logic [SUM_W-1:0]       sample_sum
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

   logic [SAMPLE_BITS-1:0] mem [AVG_DEPTH];

   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic                   wrapped_ff, wrapped_in;
   logic                   old_valid_ff, old_valid_in;
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [SAMPLE_BITS-1:0] old_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   fwd;
   logic [SAMPLE_BITS-1:0] old_eff;

   // the entry being fetched is still being written by the previous tick
   assign fwd = commit && (wr_ptr_ff == ptr_ff);

   // entries ahead of the pointer read as zero until the ring has wrapped once
   assign old_eff    = old_valid_ff ? old_ff : '0;
   assign sample_sum = sum_ff;

   always_comb begin
      ptr_in       = ptr_ff;
      wrapped_in   = wrapped_ff;
      old_valid_in = old_valid_ff;
      sum_in       = sum_ff;
      if (fetch) begin
         ptr_in       = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
         wrapped_in   = wrapped_ff || (ptr_ff == PTR_LAST);
         old_valid_in = wrapped_ff || fwd;
      end
      if (commit) begin
         sum_in = sum_ff - SUM_W'(old_eff) + SUM_W'(commit_sample);
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         mem[wr_ptr_ff] <= commit_sample;
      end
      if (fetch) begin
         old_ff    <= fwd ? commit_sample : mem[ptr_ff];
         wr_ptr_ff <= ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         wrapped_ff   <= 1'b0;
         old_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         ptr_ff       <= ptr_in;
         wrapped_ff   <= wrapped_in;
         old_valid_ff <= old_valid_in;
         sum_ff       <= sum_in;
      end
   end

endmodule

// ===== hdl/kcac_lock.sv =====
// alarm latch, keypad scan machine and code check
module kcac_lock import kcac_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  tick_type         tick,
   input  cfg_type          cfg,
   input  logic [SUM_W-1:0] sample_sum,
   output result_type       result
);

   scan_state_type scan_ff, scan_in;
   logic [3:0]     held_ff, held_in;
   logic [3:0]     dcnt_ff, dcnt_in;
   logic [3:0]     keys_ff [CODE_LEN];
   logic [3:0]     keys_in [CODE_LEN];
   logic [POS_W-1:0] pos_ff, pos_in;
   logic           alarm_ff, alarm_in;
   logic           wrong_ff, wrong_in;
   logic [3:0]     wcnt_ff, wcnt_in;
   logic           blocked_ff, blocked_in;

   logic           found;
   logic [3:0]     key;
   logic           cause;
   logic           rel;
   logic           match;

   assign {found, key} = first_key(tick.key_matrix);

   // gas and test lines are active low
   assign cause = !tick.gas_line || !tick.test_button ||
                  (32'(sample_sum) > 32'(cfg.temp_sum_limit));

   // scan machine
   always_comb begin
      scan_in = scan_ff;
      held_in = held_ff;
      dcnt_in = dcnt_ff;
      rel     = 1'b0;
      unique case (scan_ff)
         SCAN_IDLE: begin
            if (found) begin
               held_in = key;
               dcnt_in = '0;
               scan_in = SCAN_DEBOUNCE;
            end
         end
         SCAN_DEBOUNCE: begin
            if (dcnt_ff >= cfg.debounce_ticks) begin
               scan_in = (found && key == held_ff) ? SCAN_HOLD : SCAN_IDLE;
            end
            if (dcnt_ff != CNT_MAX) begin
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         SCAN_HOLD: begin
            // a different key drops back to scanning without a release
            if (!found || key != held_ff) begin
               rel     = !found;
               scan_in = SCAN_IDLE;
            end
         end
         default: scan_in = SCAN_IDLE;
      endcase
   end

   // code entry and alarm
   always_comb begin
      keys_in  = keys_ff;
      pos_in   = pos_ff;
      alarm_in = alarm_ff || cause;
      wrong_in = wrong_ff;
      wcnt_in  = wcnt_ff;
      match    = 1'b1;
      if (rel && held_ff != HASH_KEY) begin
         keys_in[pos_ff] = held_ff;
         if (pos_ff == POS_W'(CODE_LEN - 1)) begin
            pos_in = '0;
            for (int i = 0; i < CODE_LEN; i++) begin
               if (keys_in[i] != cfg.code_word[4*i +: 4]) begin
                  match = 1'b0;
               end
            end
            if (match) begin
               alarm_in = 1'b0;
               wrong_in = 1'b0;
               wcnt_in  = '0;
            end else begin
               wrong_in = 1'b1;
               if (wcnt_ff != CNT_MAX) begin
                  wcnt_in = wcnt_ff + 1'b1;
               end
            end
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
      blocked_in = blocked_ff || (wcnt_in >= cfg.block_threshold);
   end

   always_comb begin
      result.siren_on           = alarm_in;
      result.alarm_started      = cause && !alarm_ff;
      result.incorrect_flag     = wrong_in;
      result.blocked_flag       = blocked_in;
      result.key_released_valid = rel;
      result.key_released_index = rel ? held_ff : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= SCAN_IDLE;
      end else if (step) begin
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         dcnt_ff    <= '0;
         pos_ff     <= '0;
         alarm_ff   <= 1'b0;
         wrong_ff   <= 1'b0;
         wcnt_ff    <= '0;
         blocked_ff <= 1'b0;
         for (int i = 0; i < CODE_LEN; i++) begin
            keys_ff[i] <= '0;
         end
      end else if (step) begin
         held_ff    <= held_in;
         dcnt_ff    <= dcnt_in;
         pos_ff     <= pos_in;
         alarm_ff   <= alarm_in;
         wrong_ff   <= wrong_in;
         wcnt_ff    <= wcnt_in;
         blocked_ff <= blocked_in;
         keys_ff    <= keys_in;
      end
   end

endmodule

// ===== hdl/keypad_code_alarm_controller_unit.sv =====
// Keypad code lock with gas and over-temperature alarm. Each req transfer is one
// tick; it yields exactly one rsp transfer via stage one and the output register,
// and a new tick is taken every cycle while the rsp side keeps up. The sample ring
// memory reads the entry a tick overwrites when the tick is taken; the running sum
// and all keypad and alarm state are updated as the tick leaves stage one. The ring
// needs no clearing pass after reset: entries not yet written once read as zero.
// Configuration registers sit at byte addresses 0, 4, 8 and 12 of the csr port.
`include "keypad_code_alarm_controller_unit_macros.svh"

module keypad_code_alarm_controller_unit import kcac_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_gas_line,
   input  logic                  req_test_button,
   input  logic [11:0]           req_temp_sample,
   input  logic [15:0]           req_key_matrix,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_siren_on,
   output logic                  rsp_alarm_started,
   output logic                  rsp_incorrect_flag,
   output logic                  rsp_blocked_flag,
   output logic                  rsp_key_released_valid,
   output logic [3:0]            rsp_key_released_index,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type          cfg;
   tick_type         tick_in, s1_tick_ff;
   logic             s1_valid_ff, s1_valid_in;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, step_result;
   logic             accept, advance;
   logic [SUM_W-1:0] sample_sum;

   assign tick_in = '{gas_line:    req_gas_line,
                      test_button: req_test_button,
                      temp_sample: req_temp_sample,
                      key_matrix:  req_key_matrix};

   // tick in stage one moves on whenever the output register is free or drained
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign accept       = req_valid && req_ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   kcac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kcac_ring u_ring (
      .clock         (clock),
      .reset         (reset),
      .fetch         (accept),
      .commit        (advance),
      .commit_sample (s1_tick_ff.temp_sample[SAMPLE_BITS-1:0]),
      .sample_sum    (sample_sum)
   );

   kcac_lock u_lock (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .tick       (s1_tick_ff),
      .cfg        (cfg),
      .sample_sum (sample_sum),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tick_ff <= tick_in;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_siren_on           = out_ff.siren_on;
   assign rsp_alarm_started      = out_ff.alarm_started;
   assign rsp_incorrect_flag     = out_ff.incorrect_flag;
   assign rsp_blocked_flag       = out_ff.blocked_flag;
   assign rsp_key_released_valid = out_ff.key_released_valid;
   assign rsp_key_released_index = out_ff.key_released_index;

   `KCAC_ASSERT_SAME(a_stall_only_when_full, !req_ready,
      s1_valid_ff && out_valid_ff && !rsp_ready, "input stalled with room in the pipeline")
   `KCAC_ASSERT_SAME(a_no_release_index, rsp_valid && !rsp_key_released_valid,
      rsp_key_released_index == 4'd0, "release index set without a release")
   `KCAC_ASSERT_NEXT(a_blocked_sticky, rsp_valid && rsp_ready && rsp_blocked_flag,
      !rsp_valid || rsp_blocked_flag, "blocked flag cleared without reset")

endmodule

// ===== dv/tb_keypad_code_alarm_controller_unit.sv =====
// testbench for the keypad code alarm controller: directed and random ticks checked against a tick predictor
`timescale 1ns / 1ps

module tb_keypad_code_alarm_controller_unit import kcac_pkg::*;;

   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_gas_line = 1'b1;
   logic                  req_test_button = 1'b1;
   logic [11:0]           req_temp_sample = '0;
   logic [15:0]           req_key_matrix = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_siren_on;
   logic                  rsp_alarm_started;
   logic                  rsp_incorrect_flag;
   logic                  rsp_blocked_flag;
   logic                  rsp_key_released_valid;
   logic [3:0]            rsp_key_released_index;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   keypad_code_alarm_controller_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_gas_line           (req_gas_line),
      .req_test_button        (req_test_button),
      .req_temp_sample        (req_temp_sample),
      .req_key_matrix         (req_key_matrix),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_siren_on           (rsp_siren_on),
      .rsp_alarm_started      (rsp_alarm_started),
      .rsp_incorrect_flag     (rsp_incorrect_flag),
      .rsp_blocked_flag       (rsp_blocked_flag),
      .rsp_key_released_valid (rsp_key_released_valid),
      .rsp_key_released_index (rsp_key_released_index),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register copies
   logic [15:0] cfg_code       = CODE_WORD_RST;
   logic [3:0]  cfg_debounce   = DEBOUNCE_TICKS_RST;
   logic [18:0] cfg_temp_limit = TEMP_SUM_LIMIT_RST;
   logic [3:0]  cfg_block      = BLOCK_THRESHOLD_RST;

   // predicted lock and alarm state
   scan_state_type   lock_scan = SCAN_IDLE;
   logic [3:0]       lock_held = '0;
   logic [3:0]       lock_count = '0;
   logic [3:0]       lock_keys [CODE_LEN] = '{default: '0};
   int               lock_pos = 0;
   logic             alarm_on = 1'b0;
   logic             wrong_on = 1'b0;
   logic [3:0]       wrong_total = '0;
   logic             blocked_on = 1'b0;
   logic [11:0]      temp_ring [AVG_DEPTH] = '{default: '0};
   int               temp_ptr = 0;
   logic [SUM_W-1:0] temp_sum = '0;

   tick_type   tick_q [$];
   result_type status_q [$];
   tick_type   offered;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic send_hold = 1'b0;
   logic stall_request = 1'b0;
   logic stall_taken = 1'b0;
   int   stall_left = 0;
   int   mismatches = 0;
   int   results_seen = 0;
   int   ticks_queued = 0;
   int   cycles = 0;
   int   temp_lo = 0;
   int   temp_hi = 4095;

   function automatic result_type step_alarm_lock(input tick_type t);
      result_type r;
      logic       found;
      logic [3:0] idx;
      logic       matched;
      r = '0;
      // alarm causes look at the sum up to the previous tick
      if (!t.gas_line || !t.test_button || temp_sum > cfg_temp_limit) begin
         if (!alarm_on) begin
            alarm_on = 1'b1;
            r.alarm_started = 1'b1;
         end
      end
      found = 1'b0;
      idx = '0;
      for (int i = 0; i < 16; i++) begin
         if (!found && t.key_matrix[i]) begin
            found = 1'b1;
            idx = 4'(i);
         end
      end
      case (lock_scan)
         SCAN_IDLE: begin
            if (found) begin
               lock_held = idx;
               lock_count = '0;
               lock_scan = SCAN_DEBOUNCE;
            end
         end
         SCAN_DEBOUNCE: begin
            if (lock_count >= cfg_debounce)
               lock_scan = (found && idx == lock_held) ? SCAN_HOLD : SCAN_IDLE;
            if (lock_count != CNT_MAX)
               lock_count++;
         end
         SCAN_HOLD: begin
            if (!found || idx != lock_held) begin
               if (!found) begin
                  r.key_released_valid = 1'b1;
                  r.key_released_index = lock_held;
               end
               lock_scan = SCAN_IDLE;
            end
         end
         default: lock_scan = SCAN_IDLE;
      endcase
      if (r.key_released_valid && r.key_released_index != HASH_KEY) begin
         if (lock_pos < CODE_LEN) begin
            lock_keys[lock_pos] = r.key_released_index;
            lock_pos++;
         end
         if (lock_pos >= CODE_LEN) begin
            matched = 1'b1;
            for (int j = 0; j < CODE_LEN; j++)
               if (lock_keys[j] != cfg_code[4*j +: 4])
                  matched = 1'b0;
            if (matched) begin
               alarm_on = 1'b0;
               wrong_on = 1'b0;
               wrong_total = '0;
            end else begin
               wrong_on = 1'b1;
               if (wrong_total != CNT_MAX)
                  wrong_total++;
            end
            lock_pos = 0;
         end
      end
      if (wrong_total >= cfg_block)
         blocked_on = 1'b1;
      temp_sum = temp_sum - SUM_W'(temp_ring[temp_ptr]) + SUM_W'(t.temp_sample);
      temp_ring[temp_ptr] = t.temp_sample;
      temp_ptr = (temp_ptr + 1 >= AVG_DEPTH) ? 0 : temp_ptr + 1;
      r.siren_on = alarm_on;
      r.incorrect_flag = wrong_on;
      r.blocked_flag = blocked_on;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < 50)
         $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // driver: a new tick is offered only once the previous one has been taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            status_q.push_back(step_alarm_lock(offered));
         if (tick_q.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
            offered = tick_q.pop_front();
            req_gas_line <= offered.gas_line;
            req_test_button <= offered.test_button;
            req_temp_sample <= offered.temp_sample;
            req_key_matrix <= offered.key_matrix;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = status_q.pop_front();
               if (rsp_siren_on !== want.siren_on)
                  report_mismatch($sformatf("result %0d siren_on %b want %b",
                     results_seen, rsp_siren_on, want.siren_on));
               if (rsp_alarm_started !== want.alarm_started)
                  report_mismatch($sformatf("result %0d alarm_started %b want %b",
                     results_seen, rsp_alarm_started, want.alarm_started));
               if (rsp_incorrect_flag !== want.incorrect_flag)
                  report_mismatch($sformatf("result %0d incorrect_flag %b want %b",
                     results_seen, rsp_incorrect_flag, want.incorrect_flag));
               if (rsp_blocked_flag !== want.blocked_flag)
                  report_mismatch($sformatf("result %0d blocked_flag %b want %b",
                     results_seen, rsp_blocked_flag, want.blocked_flag));
               if (rsp_key_released_valid !== want.key_released_valid)
                  report_mismatch($sformatf("result %0d key_released_valid %b want %b",
                     results_seen, rsp_key_released_valid, want.key_released_valid));
               if (rsp_key_released_index !== want.key_released_index)
                  report_mismatch($sformatf("result %0d key_released_index %0d want %0d",
                     results_seen, rsp_key_released_index, want.key_released_index));
            end
            results_seen++;
         end
         rsp_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off, started once on request
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_request && !stall_taken) begin
         stall_left <= 300;
         stall_taken <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_keypad_code_alarm_controller_unit NOT OK");
         $finish;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] want;
      case (idx)
         REG_CODE_WORD:       want = {16'h0, value[15:0]};
         REG_DEBOUNCE_TICKS:  want = {28'h0, value[3:0]};
         REG_TEMP_SUM_LIMIT:  want = {13'h0, value[18:0]};
         default:             want = {28'h0, value[3:0]};
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_CODE_WORD:       cfg_code = want[15:0];
         REG_DEBOUNCE_TICKS:  cfg_debounce = want[3:0];
         REG_TEMP_SUM_LIMIT:  cfg_temp_limit = want[18:0];
         default:             cfg_block = want[3:0];
      endcase
      // read back straight after
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %s read %h want %h", idx.name(), csr_prdata, want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_tick(input logic [15:0] matrix, input int gas_pct, input int test_pct);
      tick_type t;
      t.gas_line = ($urandom_range(99) < gas_pct) ? 1'b0 : 1'b1;
      t.test_button = ($urandom_range(99) < test_pct) ? 1'b0 : 1'b1;
      t.temp_sample = 12'($urandom_range(temp_hi, temp_lo));
      t.key_matrix = matrix;
      tick_q.push_back(t);
      ticks_queued++;
   endtask

   // press for the given ticks, sometimes with higher keys down as well, then release
   task automatic press_key(input logic [3:0] key, input int hold_len);
      logic [15:0] above;
      logic [15:0] extra;
      above = 16'hFFFF << (int'(key) + 1);
      extra = ($urandom_range(3) == 0) ? (16'($urandom()) & above) : 16'h0;
      repeat (hold_len)
         queue_tick((16'h1 << key) | extra, 2, 2);
      queue_tick(16'h0, 10, 5);
      repeat ($urandom_range(1))
         queue_tick(16'h0, 2, 2);
   endtask

   task automatic enter_code(input logic correct);
      logic [3:0] key;
      for (int i = 0; i < CODE_LEN; i++) begin
         if ($urandom_range(9) == 0)
            press_key(HASH_KEY, cfg_debounce + 2);
         key = correct ? cfg_code[4*i +: 4] : 4'($urandom_range(15));
         press_key(key, cfg_debounce + 2 + $urandom_range(2));
      end
   endtask

   task automatic random_phase(input int n_ticks);
      int goal;
      int pick;
      logic [3:0] first_key;
      logic [3:0] other_key;
      goal = ticks_queued + n_ticks;
      while (ticks_queued < goal) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            temp_lo = 0;
            temp_hi = 300;
         end else if (pick < 70) begin
            temp_lo = 400;
            temp_hi = 900;
         end else begin
            temp_lo = 0;
            temp_hi = 4095;
         end
         pick = $urandom_range(99);
         if (pick < 40) begin
            enter_code(1'b1);
         end else if (pick < 70) begin
            enter_code(1'b0);
         end else if (pick < 80) begin
            press_key(HASH_KEY, cfg_debounce + 2 + $urandom_range(3));
         end else if (pick < 90) begin
            first_key = 4'($urandom_range(15));
            if ($urandom_range(1)) begin
               // released before the debounce check can pass
               repeat ($urandom_range(int'(cfg_debounce) + 1, 1))
                  queue_tick(16'h1 << first_key, 2, 2);
               queue_tick(16'h0, 2, 2);
            end else begin
               // another key takes over while held: no release
               other_key = first_key + 4'($urandom_range(15, 1));
               repeat (int'(cfg_debounce) + 2 + $urandom_range(2))
                  queue_tick(16'h1 << first_key, 2, 2);
               repeat (2)
                  queue_tick(16'h1 << other_key, 2, 2);
               repeat (2)
                  queue_tick(16'h0, 2, 2);
            end
         end else begin
            repeat ($urandom_range(8, 3))
               queue_tick(($urandom_range(3) == 0) ? 16'h0 : 16'($urandom()), 20, 20);
            repeat (2)
               queue_tick(16'h0, 2, 2);
         end
      end
   endtask

   task automatic drain();
      do
         @(posedge clock);
      while (tick_q.size() != 0 || req_valid || status_q.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 26;
      recv_idle_pct = 53;

      // directed ticks, debounce off so each press is short
      csr_write(REG_DEBOUNCE_TICKS, 32'd0);
      temp_lo = 4095;
      temp_hi = 4095;
      queue_tick(16'h0, 100, 0);
      temp_lo = 0;
      temp_hi = 0;
      queue_tick(16'h0, 0, 100);
      temp_hi = 4095;
      repeat (2) queue_tick(16'hFFFF, 0, 0);
      queue_tick(16'h0, 0, 0);
      repeat (2) queue_tick(16'h8000, 0, 0);
      queue_tick(16'h0, 0, 0);
      repeat (2) queue_tick(16'h4000, 0, 0);
      queue_tick(16'h0, 0, 0);
      repeat (2) queue_tick(16'h0001, 0, 0);
      queue_tick(16'h0002, 0, 0);
      queue_tick(16'h0, 0, 0);
      for (int i = 0; i < CODE_LEN; i++) begin
         repeat (2) queue_tick(16'h1 << cfg_code[4*i +: 4], 0, 0);
         queue_tick(16'h0, 0, 0);
      end
      drain();

      // no debounce, alarm on any warmth, highest threshold
      csr_write(REG_CODE_WORD, {16'h0, 16'($urandom()) & 16'hDDDD});
      csr_write(REG_TEMP_SUM_LIMIT, 32'd0);
      csr_write(REG_BLOCK_THRESHOLD, 32'd15);
      random_phase(350);
      drain();

      // longest debounce, temperature limit out of reach, long receiver hold-off
      csr_write(REG_CODE_WORD, {16'h0, CODE_WORD_RST});
      csr_write(REG_DEBOUNCE_TICKS, 32'd15);
      csr_write(REG_TEMP_SUM_LIMIT, 32'd409500);
      csr_write(REG_BLOCK_THRESHOLD, 32'd1);
      random_phase(500);
      do @(posedge clock); while (tick_q.size() > 250);
      stall_request <= 1'b1;
      drain();

      // idling swapped, zero threshold, sender pauses until all results are back
      send_idle_pct = 53;
      recv_idle_pct = 26;
      csr_write(REG_CODE_WORD, 32'h0000FFFF);
      csr_write(REG_DEBOUNCE_TICKS, $urandom_range(6, 1));
      csr_write(REG_TEMP_SUM_LIMIT, {13'h0, TEMP_SUM_LIMIT_RST});
      csr_write(REG_BLOCK_THRESHOLD, 32'd0);
      random_phase(450);
      do @(posedge clock); while (tick_q.size() > 225);
      send_hold = 1'b1;
      do @(posedge clock); while (req_valid || status_q.size() != 0);
      send_hold = 1'b0;
      drain();

      // full rate
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(REG_CODE_WORD, 32'h0);
      csr_write(REG_DEBOUNCE_TICKS, 32'd2);
      csr_write(REG_TEMP_SUM_LIMIT, $urandom_range(100000, 30000));
      csr_write(REG_BLOCK_THRESHOLD, 32'd3);
      random_phase(400);
      drain();

      if (mismatches == 0)
         $display("tb_keypad_code_alarm_controller_unit OK");
      else
         $display("tb_keypad_code_alarm_controller_unit NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/kcac_pkg.sv
hdl/kcac_csr.sv
hdl/kcac_ring.sv
hdl/kcac_lock.sv
hdl/keypad_code_alarm_controller_unit.sv
dv/tb_keypad_code_alarm_controller_unit.sv
